// ===== rtl/rmwd_pkg.sv =====
package rmwd_pkg;

    localparam int GAIN_BITS      = 16;
    localparam int SINE_BITS      = 16;
    localparam int STEP_BITS      = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    // dry*2^15 + sine*wet fits 33 bits signed
    localparam int MIX_BITS       = 33;

    localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd42852281;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd16384;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_DRY_GAIN   = 2'd1,
        CFG_WET_GAIN   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WET,
        ST_MIX,
        ST_DONE
    } rmwd_state_t;

    // odd polynomial coefficients for sin over a quarter turn, Q30
    localparam logic [63:0] POLY_C1 = 64'd1686629713;
    localparam logic [63:0] POLY_C3 = 64'd693598668;
    localparam logic [63:0] POLY_C5 = 64'd85569306;
    localparam logic [63:0] POLY_C7 = 64'd5026995;
    localparam logic [63:0] POLY_C9 = 64'd172272;

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod >> 30;
    endfunction

    // One table entry; evaluated at elaboration only.
    function automatic logic signed [SINE_BITS-1:0] sine_entry(
        input int unsigned idx,
        input int unsigned addr_bits
    );
        int unsigned qbits;
        int unsigned quarter;
        int unsigned quad;
        int unsigned r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] v;
        logic signed [SINE_BITS-1:0] mag;
        qbits   = addr_bits - 2;
        quarter = 1 << qbits;
        quad    = (idx >> qbits) & 3;
        r       = idx & (quarter - 1);
        if ((quad & 1) != 0)
        begin
            r = quarter - r;
        end
        z  = 64'(r) << (30 - qbits);
        z2 = q30_mul(z, z);
        p  = POLY_C7 - q30_mul(z2, POLY_C9);
        p  = POLY_C5 - q30_mul(z2, p);
        p  = POLY_C3 - q30_mul(z2, p);
        p  = POLY_C1 - q30_mul(z2, p);
        v  = q30_mul(z, p);
        v  = (v + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        mag = SINE_BITS'(v);
        return ((quad & 2) != 0) ? -mag : mag;
    endfunction

endpackage

// ===== rtl/rmwd_sample_if.sv =====
interface rmwd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/rmwd_result_if.sv =====
interface rmwd_result_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/ring_modulator_wet_dry_unit.sv =====
// Ring modulator with wet/dry mix, sine carrier from a phase accumulator.
// samples (sink): one signed audio sample per transaction, valid/ready.
// results (source): one saturated mix sample per input transaction.
// cfg_we/cfg_index/cfg_data: write-only register port, index 0 phase_step,
// 1 dry_gain, 2 wet_gain; other indexes are ignored. Write only while idle.
// A sample is taken only in the idle state and runs through two bit-serial
// shift-add passes: sine*wet_gain plus dry_gain, then the sample times that
// 33-bit mix factor. The result is then loaded into the output register and
// the block returns to idle, so a new sample is taken only once the previous
// result has been loaded.
// The carrier phase advances by phase_step when a result is loaded, so
// interleaved channels share one oscillator.
// Reset: phase clears, gains return to 0.5, phase_step to its default, no
// result pending. The sine ROM is constant and needs no fill.
// Stall: a result waits in the output register; the next computed result
// holds in the done state until that register frees, and samples.ready is
// low from acceptance until the result is loaded.
module ring_modulator_wet_dry_unit #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rmwd_sample_if.sink                         samples,
    rmwd_result_if.source                       results,
    input  logic                                cfg_we,
    input  logic [rmwd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rmwd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rmwd_pkg::*;

    localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
    // first pass: hi part holds partial sums of sine*wet plus dry
    localparam int WET_HI     = SINE_BITS + 2;
    localparam int WET_W      = WET_HI + GAIN_BITS;
    // second pass: hi part holds partial sums of the sample
    localparam int MIX_HI     = SAMPLE_BITS + 2;
    localparam int MIX_W      = MIX_HI + MIX_BITS;
    localparam int CNT_BITS   = $clog2(MIX_BITS);
    localparam int ROUND_STEP = 29;  // rounding constant 2^29
    localparam int Y_LSB      = 30;
    localparam int SAT_BITS   = MIX_W - Y_LSB - SAMPLE_BITS + 1;

    typedef logic signed [SINE_BITS-1:0] rom_t [TABLE_SIZE];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            rom[i] = sine_entry(i, TABLE_ADDR_BITS);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // control
    rmwd_state_t             state_reg, state_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic [GAIN_BITS-1:0]    dry_reg, dry_next;
    logic [GAIN_BITS-1:0]    wetg_reg, wetg_next;

    // datapath
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SINE_BITS-1:0]   sine_reg;
    logic [WET_W-1:0]              wet_acc_reg;
    logic [MIX_W-1:0]              mix_acc_reg;
    logic [SAMPLE_BITS-1:0]        out_reg;

    logic                   in_acc;
    logic                   out_load;
    logic                   wet_last;
    logic                   mix_last;
    logic [WET_HI-1:0]      wet_sum;
    logic [WET_W-1:0]       wet_shift;
    logic [MIX_HI-1:0]      x_ext;
    logic [MIX_HI-1:0]      mix_add;
    logic [MIX_HI-1:0]      mix_sum;
    logic [MIX_W-1:0]       mix_shift;
    logic [SAT_BITS-1:0]    sat_top;
    logic [SAMPLE_BITS-1:0] y_sat;

    assign in_acc   = samples.valid && samples.ready;
    assign wet_last = (cnt_reg == CNT_BITS'(GAIN_BITS - 1));
    assign mix_last = (cnt_reg == CNT_BITS'(MIX_BITS - 1));

    // sine ROM, registered read; phase is steady while an item is in work
    always_ff @(posedge clk)
    begin
        sine_reg <= SINE_ROM[phase_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS]];
    end

    // pass 1: g = sine*wet_gain + dry_gain*2^15, LSB of wet_gain first
    always_comb
    begin
        wet_sum = wet_acc_reg[WET_W-1 -: WET_HI]
                + (wet_acc_reg[0] ? WET_HI'(sine_reg) : '0)
                + (wet_last ? WET_HI'(dry_reg) : '0);
        wet_shift = {wet_sum[WET_HI-1], wet_sum, wet_acc_reg[GAIN_BITS-1:1]};
    end

    // pass 2: sample * g, g is signed so its top bit subtracts;
    // the rounding constant enters as a carry at its own step
    always_comb
    begin
        x_ext   = MIX_HI'(x_reg);
        mix_add = '0;
        if (mix_acc_reg[0])
        begin
            mix_add = mix_last ? (~x_ext + MIX_HI'(1)) : x_ext;
        end
        mix_sum = mix_acc_reg[MIX_W-1 -: MIX_HI] + mix_add
                + MIX_HI'(cnt_reg == CNT_BITS'(ROUND_STEP));
        mix_shift = {mix_sum[MIX_HI-1], mix_sum, mix_acc_reg[MIX_BITS-1:1]};
    end

    // saturate the rounded product, bits above Y_LSB
    always_comb
    begin
        sat_top = mix_acc_reg[MIX_W-1 -: SAT_BITS];
        if ((sat_top == '0) || (sat_top == '1))
        begin
            y_sat = mix_acc_reg[Y_LSB +: SAMPLE_BITS];
        end
        else
        begin
            y_sat = mix_acc_reg[MIX_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg       <= samples.sample_in;
            wet_acc_reg <= {{WET_HI{1'b0}}, wetg_reg};
        end
        if (state_reg == ST_WET)
        begin
            wet_acc_reg <= wet_shift;
            if (wet_last)
            begin
                mix_acc_reg <= {{MIX_HI{1'b0}}, wet_shift[MIX_BITS-1:0]};
            end
        end
        if (state_reg == ST_MIX)
        begin
            mix_acc_reg <= mix_shift;
        end
        if (out_load)
        begin
            out_reg <= y_sat;
        end
    end

    // state machine, step counter and output handshake
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        samples.ready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    state_next = ST_WET;
                    cnt_next   = '0;
                end
            end
            ST_WET:
            begin
                if (wet_last)
                begin
                    state_next = ST_MIX;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            ST_MIX:
            begin
                if (mix_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        phase_next = phase_reg;
        if (out_load)
        begin
            phase_next = phase_reg + PHASE_BITS'(step_reg);
        end

        step_next = step_reg;
        dry_next  = dry_reg;
        wetg_next = wetg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP: step_next = cfg_data[STEP_BITS-1:0];
                CFG_DRY_GAIN:   dry_next  = cfg_data[GAIN_BITS-1:0];
                CFG_WET_GAIN:   wetg_next = cfg_data[GAIN_BITS-1:0];
                default:        step_next = step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            step_reg      <= STEP_RESET;
            dry_reg       <= GAIN_RESET;
            wetg_reg      <= GAIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            dry_reg       <= dry_next;
            wetg_reg      <= wetg_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_reg;

endmodule

// ===== rtl/rmwd_checker.sv =====
module rmwd_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_data
);
    // a stalled transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // one sample in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in work");

    // the serial passes lie between input and result, a result never follows at once
    a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared right after input");
endmodule

bind ring_modulator_wet_dry_unit rmwd_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_rmwd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.sample_out)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Testbench for ring_modulator_wet_dry_unit.
// A local model of the block keeps its own carrier phase, its own sine table
// and its own copy of the three registers. When a sample transaction is
// accepted, the model computes the mix and queues it. Every result
// transaction is checked against the oldest queued value. Registers are
// written only when no result is outstanding. Both channels idle at random,
// and the result side is held off twice for long enough that the block
// stalls its input.
module tb;
    import rmwd_pkg::*;

    localparam int SAMPLE_W     = 16;
    localparam int ITEM_TARGET  = 1400;
    // Longest quiet stretch of a correct run: the result hold-off plus one
    // computation plus sender gaps. Taken about ten times.
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int END_SETTLE   = 60;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NO_REG = 2'd3;

    // Q30 odd-polynomial coefficients of sin over a quarter turn
    localparam longint unsigned SIN_K1 = 64'd1686629713;
    localparam longint unsigned SIN_K3 = 64'd693598668;
    localparam longint unsigned SIN_K5 = 64'd85569306;
    localparam longint unsigned SIN_K7 = 64'd5026995;
    localparam longint unsigned SIN_K9 = 64'd172272;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    rmwd_sample_if #(.SAMPLE_BITS(SAMPLE_W)) smp ();
    rmwd_result_if #(.SAMPLE_BITS(SAMPLE_W)) res ();

    ring_modulator_wet_dry_unit #(
        .PHASE_BITS      (32),
        .TABLE_ADDR_BITS (10),
        .SAMPLE_BITS     (SAMPLE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (smp),
        .results   (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state: oscillator, registers, carrier table
    logic [31:0]                osc_phase;
    logic [STEP_BITS-1:0]       step_reg;
    logic [GAIN_BITS-1:0]       dry_reg;
    logic [GAIN_BITS-1:0]       wet_reg;
    logic signed [SINE_BITS-1:0] carrier_rom [0:1023];

    logic signed [SAMPLE_W-1:0] expected_mix [$];
    int mismatches      = 0;
    int items_sent      = 0;
    int idle_pct_src    = 24;
    int idle_pct_sink   = 24;
    int ready_hold_req  = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One carrier table entry: fold into the first quarter, evaluate the
    // polynomial with Q30 truncating products, round half up to Q15.
    function automatic logic signed [SINE_BITS-1:0] sine_q15(input int unsigned idx);
        longint unsigned r;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned v;
        int unsigned quad;
        logic signed [SINE_BITS-1:0] mag;
        quad = (idx >> 8) & 3;
        r    = idx & 255;
        if ((quad & 1) != 0)
        begin
            r = 256 - r;
        end
        z  = r << 22;
        z2 = (z * z) >> 30;
        p  = SIN_K7 - ((z2 * SIN_K9) >> 30);
        p  = SIN_K5 - ((z2 * p) >> 30);
        p  = SIN_K3 - ((z2 * p) >> 30);
        p  = SIN_K1 - ((z2 * p) >> 30);
        v  = (z * p) >> 30;
        v  = (v + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        mag = SINE_BITS'(v);
        return ((quad & 2) != 0) ? -mag : mag;
    endfunction

    // Dry/wet mix of one sample at the current phase, then advance the phase.
    function automatic logic signed [SAMPLE_W-1:0] predict_mix(
        input logic signed [SAMPLE_W-1:0] x
    );
        logic signed [SINE_BITS-1:0] carrier;
        longint acc;
        longint y;
        carrier = carrier_rom[osc_phase[31:22]];
        acc = longint'(x) * longint'(dry_reg) * 64'sd32768
            + longint'(x) * longint'(carrier) * longint'(wet_reg);
        // round half up, floor shift
        y = (acc + 64'sd536870912) >>> 30;
        if (y > 64'sd32767)
        begin
            y = 64'sd32767;
        end
        if (y < -64'sd32768)
        begin
            y = -64'sd32768;
        end
        osc_phase = osc_phase + step_reg;
        return SAMPLE_W'(y);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return SAMPLE_W'($urandom_range(0, 64) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'd65535;
            3:       return GAIN_RESET;
            default: return GAIN_BITS'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [STEP_BITS-1:0] pick_step();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hffff_ffff;
            3:       return 32'h8000_0000;
            4:       return STEP_RESET;
            5:       return STEP_BITS'($urandom_range(0, 1 << 24));
            default: return STEP_BITS'($urandom);
        endcase
    endfunction

    // Register write; the model follows at once since the block is idle.
    // Always leaves cfg_we low for one edge so back-to-back calls never
    // lower and raise it in the same time step.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_PHASE_STEP: step_reg = data;
            CFG_DRY_GAIN:   dry_reg  = data[GAIN_BITS-1:0];
            CFG_WET_GAIN:   wet_reg  = data[GAIN_BITS-1:0];
            default:        ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Gain write, sometimes with junk in the upper half of the data word
    task automatic write_gain(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [GAIN_BITS-1:0] gain);
        logic [15:0] junk;
        junk = ($urandom_range(1) == 1) ? 16'($urandom) : 16'd0;
        write_reg(idx, {junk, gain});
    endtask

    // Offer one sample, with random idle cycles first. Called and returns
    // right after a rising edge.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < idle_pct_src)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid     <= 1'b1;
        smp.sample_in <= x;
        do
            @(posedge clk);
        while (!smp.ready);
        expected_mix.push_back(predict_mix(x));
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    // Always advances at least one edge.
    task automatic wait_drained();
        smp.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_mix.size() != 0);
    endtask

    // Out of reset: phase 0 means zero carrier, so the first result is the
    // dry half alone.
    task automatic test_reset_defaults();
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd12345);
        wait_drained();
    endtask

    // Gain and step extremes, saturation both ways, unknown register index.
    task automatic test_directed_extremes();
        // dry only at unity gain: straight pass-through
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        write_gain(CFG_DRY_GAIN, 16'd32768);
        write_gain(CFG_WET_GAIN, 16'd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        wait_drained();

        // both gains near 2.0: sum saturates high and low
        write_gain(CFG_DRY_GAIN, 16'd65535);
        write_gain(CFG_WET_GAIN, 16'd65535);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        wait_drained();

        // wet only: ring modulation across all four quarters
        write_gain(CFG_DRY_GAIN, 16'd0);
        write_gain(CFG_WET_GAIN, 16'd32768);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sd0);
        send_sample(16'sd1);
        wait_drained();

        // write to an unmapped index must leave phase_step alone
        write_reg(CFG_PHASE_STEP, 32'h8000_0000);
        write_reg(CFG_NO_REG, 32'hffff_ffff);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        wait_drained();

        // largest step: phase walks backwards by one LSB
        write_reg(CFG_PHASE_STEP, 32'hffff_ffff);
        write_gain(CFG_DRY_GAIN, 16'd16384);
        send_sample(16'sh5555);
        send_sample(-16'sh5556);
        wait_drained();

        // zero step and zero gains
        write_reg(CFG_PHASE_STEP, 32'd0);
        write_gain(CFG_DRY_GAIN, 16'd0);
        write_gain(CFG_WET_GAIN, 16'd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        wait_drained();
    endtask

    // Results held off long enough that the output register and the done
    // state both fill and the block drops samples.ready.
    task automatic test_result_backpressure();
        write_reg(CFG_PHASE_STEP, pick_step());
        write_gain(CFG_DRY_GAIN, pick_gain());
        write_gain(CFG_WET_GAIN, pick_gain());
        idle_pct_src   = 0;
        ready_hold_req = HOLD_CYCLES;
        repeat (10) send_sample(pick_sample());
        wait_drained();
        idle_pct_src = 24;
    endtask

    // Random phases of traffic, each under a fresh register setting. One
    // phase runs with no idling on either side; now and then the sender
    // pauses until everything outstanding has come back.
    task automatic test_random_traffic();
        int phase_no;
        int n;
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(2) != 0)
            begin
                write_reg(CFG_PHASE_STEP, pick_step());
            end
            if ($urandom_range(2) != 0)
            begin
                write_gain(CFG_DRY_GAIN, pick_gain());
            end
            if ($urandom_range(2) != 0)
            begin
                write_gain(CFG_WET_GAIN, pick_gain());
            end
            if (phase_no == 3)
            begin
                idle_pct_src  = 0;
                idle_pct_sink = 0;
                n = 250;
            end
            else
            begin
                idle_pct_src  = 24;
                idle_pct_sink = 24;
                n = $urandom_range(20, 120);
            end
            if (phase_no == 6)
            begin
                ready_hold_req = HOLD_CYCLES;
            end
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(149) == 0)
                begin
                    wait_drained();
                end
                send_sample(pick_sample());
            end
            wait_drained();
            phase_no++;
        end
        idle_pct_src  = 24;
        idle_pct_sink = 24;
    endtask

    // Result side: random stalls, plus a long hold-off when asked for,
    // counted here.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold_req > 0)
            begin
                stall_left     = ready_hold_req;
                ready_hold_req = 0;
            end
            if (stall_left > 0)
            begin
                res.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready <= ($urandom_range(99) >= idle_pct_sink);
            end
        end
    end

    // Each result transaction against the oldest expectation
    always @(posedge clk)
    begin : result_check
        logic signed [SAMPLE_W-1:0] want;
        if (res.valid && res.ready)
        begin
            if (expected_mix.size() == 0)
            begin
                $error("sample_out: no result expected, got %0d", res.sample_out);
                mismatches++;
            end
            else
            begin
                want = expected_mix.pop_front();
                if (res.sample_out !== want)
                begin
                    $error("sample_out: expected %0d, actual %0d", want, res.sample_out);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if no transaction of any kind happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((smp.valid && smp.ready) || (res.valid && res.ready) || cfg_we)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $error("no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_mix.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        smp.valid     <= 1'b0;
        smp.sample_in <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;

        for (int i = 0; i < 1024; i++)
        begin
            carrier_rom[i] = sine_q15(i);
        end
        osc_phase = 32'd0;
        step_reg  = STEP_RESET;
        dry_reg   = GAIN_RESET;
        wet_reg   = GAIN_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_result_backpressure();
        test_random_traffic();

        // let any stray extra result show up before judging
        wait_drained();
        repeat (END_SETTLE) @(posedge clk);

        if (mismatches == 0 && expected_mix.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
